FILE: rtl/core/rba_pkg.sv
// rba_pkg: shared widths, register indexes, reset values and types for the
// rectangle blit / alpha blend core. No dependencies.
package rba_pkg;

	localparam int ADDR_W     = 18;
	localparam int BYTE_W     = 8;
	localparam int DIM_W      = 9;
	localparam int BPP_W      = 3;
	localparam int POS_W      = 8;
	localparam int ALPHA_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam int DEF_MAX_IMAGE_DIM       = 256;
	localparam int DEF_MAX_BYTES_PER_PIXEL = 4;

	localparam logic [CFG_IDX_W-1:0] REG_DST_IMAGE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_X           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_Y           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA           = 3'd7;

	localparam logic [DIM_W-1:0]   RST_DST_IMAGE_WIDTH = 9'd256;
	localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIXEL = 3'd4;
	localparam logic [DIM_W-1:0]   RST_RECT_WIDTH      = 9'd128;
	localparam logic [DIM_W-1:0]   RST_RECT_HEIGHT     = 9'd128;
	localparam logic [ALPHA_W-1:0] RST_ALPHA           = 8'd255;

	// configuration as seen by the datapath, rectangle sizes and bytes per pixel already clamped
	typedef struct packed {
		logic [DIM_W-1:0]   dst_width;
		logic [BPP_W-1:0]   bpp;
		logic [DIM_W-1:0]   rect_w;
		logic [DIM_W-1:0]   rect_h;
		logic [POS_W-1:0]   dst_x;
		logic [POS_W-1:0]   dst_y;
		logic               blend_en;
		logic [ALPHA_W-1:0] alpha;
	} cfg_t;

	// stage 1 contents: one request with its pixel index
	typedef struct packed {
		logic [BYTE_W-1:0]  src;
		logic [BYTE_W-1:0]  dst;
		logic [ADDR_W-1:0]  pix_idx;
		logic [BPP_W-1:0]   byte_idx;
		logic [BPP_W-1:0]   bpp;
		logic               blend_en;
		logic [ALPHA_W-1:0] alpha;
		logic               last;
	} s1_t;

endpackage

FILE: rtl/core/rect_blit_alpha_blend_core.sv
// Rectangle blit / alpha blend core: one request in and one write out per
// clock while the output is not stalled. The first stage forms the pixel
// index from the position counters (one row * stride multiply), the second
// scales it by bytes per pixel and blends the source and destination bytes;
// an output stall holds the result register and backs up into the first
// stage only when both stages are full. Depends on rba_pkg, rba_cfg_regs,
// rba_addr_seq and rba_wr_stage.
module rect_blit_alpha_blend_core import rba_pkg::*; #(
	parameter int MAX_IMAGE_DIM       = DEF_MAX_IMAGE_DIM,
	parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     src_byte,
	input  logic [BYTE_W-1:0]     dst_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [ADDR_W-1:0]     dst_addr,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  last
);

	cfg_t              cfg;
	s1_t               req_s1;
	logic              valid_s1;
	logic              accept;
	logic              adv2;
	logic [ADDR_W-1:0] pix_idx;
	logic [BPP_W-1:0]  byte_idx;
	logic              seq_last;
	logic [ADDR_W-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;

	rba_cfg_regs #(
		.MAX_IMAGE_DIM      (MAX_IMAGE_DIM),
		.MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	rba_addr_seq #(
		.MAX_IMAGE_DIM      (MAX_IMAGE_DIM),
		.MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.pix_idx (pix_idx),
		.byte_idx(byte_idx),
		.last    (seq_last)
	);

	rba_wr_stage u_wr (
		.s1  (req_s1),
		.addr(wr_addr),
		.data(wr_data)
	);

	assign adv2     = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !adv2;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv2);
			if (adv2)
				out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.src      <= src_byte;
			req_s1.dst      <= dst_byte;
			req_s1.pix_idx  <= pix_idx;
			req_s1.byte_idx <= byte_idx;
			req_s1.bpp      <= cfg.bpp;
			req_s1.blend_en <= cfg.blend_en;
			req_s1.alpha    <= cfg.alpha;
			req_s1.last     <= seq_last;
		end
		if (adv2 && valid_s1) begin
			dst_addr <= wr_addr;
			out_byte <= wr_data;
			last     <= req_s1.last;
		end
	end

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost in stage 1");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv2 |=> out_valid)
		else $error("stage 1 request not presented at output");

endmodule

FILE: rtl/core/rba_cfg_regs.sv
// rba_cfg_regs: configuration register file with range clamping of the rectangle sizes and bytes per pixel.
// Depends on rba_pkg.
module rba_cfg_regs import rba_pkg::*; #(
	parameter int MAX_IMAGE_DIM       = DEF_MAX_IMAGE_DIM,
	parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [DIM_W-1:0]   dst_width_q;
	logic [BPP_W-1:0]   bpp_q;
	logic [DIM_W-1:0]   rect_w_q;
	logic [DIM_W-1:0]   rect_h_q;
	logic [POS_W-1:0]   dst_x_q;
	logic [POS_W-1:0]   dst_y_q;
	logic               blend_en_q;
	logic [ALPHA_W-1:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_width_q <= RST_DST_IMAGE_WIDTH;
			bpp_q       <= RST_BYTES_PER_PIXEL;
			rect_w_q    <= RST_RECT_WIDTH;
			rect_h_q    <= RST_RECT_HEIGHT;
			dst_x_q     <= '0;
			dst_y_q     <= '0;
			blend_en_q  <= 1'b0;
			alpha_q     <= RST_ALPHA;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DST_IMAGE_WIDTH: dst_width_q <= cfg_wdata[DIM_W-1:0];
				REG_BYTES_PER_PIXEL: bpp_q       <= cfg_wdata[BPP_W-1:0];
				REG_RECT_WIDTH:      rect_w_q    <= cfg_wdata[DIM_W-1:0];
				REG_RECT_HEIGHT:     rect_h_q    <= cfg_wdata[DIM_W-1:0];
				REG_DST_X:           dst_x_q     <= cfg_wdata[POS_W-1:0];
				REG_DST_Y:           dst_y_q     <= cfg_wdata[POS_W-1:0];
				REG_BLEND_ENABLE:    blend_en_q  <= cfg_wdata[0];
				REG_ALPHA:           alpha_q     <= cfg_wdata[ALPHA_W-1:0];
				default:             ;
			endcase
		end
	end

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (32'(v) > MAX_IMAGE_DIM)
			r = DIM_W'(MAX_IMAGE_DIM);
		return r;
	endfunction

	always_comb begin
		cfg           = '0;
		cfg.dst_width = dst_width_q;
		cfg.rect_w    = clamp_dim(rect_w_q);
		cfg.rect_h    = clamp_dim(rect_h_q);
		cfg.dst_x     = dst_x_q;
		cfg.dst_y     = dst_y_q;
		cfg.blend_en  = blend_en_q;
		cfg.alpha     = alpha_q;
		priority if (bpp_q == '0)
			cfg.bpp = BPP_W'(1);
		else if (32'(bpp_q) > MAX_BYTES_PER_PIXEL)
			cfg.bpp = BPP_W'(MAX_BYTES_PER_PIXEL);
		else
			cfg.bpp = bpp_q;
	end

endmodule

FILE: rtl/core/rba_addr_seq.sv
// rba_addr_seq: row/column/byte position counters and the pixel index of the
// current position in the destination image. Depends on rba_pkg.
module rba_addr_seq import rba_pkg::*; #(
	parameter int MAX_IMAGE_DIM       = DEF_MAX_IMAGE_DIM,
	parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BYTES_PER_PIXEL
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              advance,
	output logic [ADDR_W-1:0] pix_idx,
	output logic [BPP_W-1:0]  byte_idx,
	output logic              last
);

	localparam int CW    = $clog2(MAX_IMAGE_DIM);
	localparam int BW    = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
	localparam int CMPW  = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
	localparam int BCMPW = (BW + 1 > BPP_W) ? BW + 1 : BPP_W;
	localparam int RSW   = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [BW-1:0]  byte_q;
	logic           end_px;
	logic           end_row;
	logic [RSW-1:0] row_sum;

	assign end_px  = (BCMPW'(byte_q) + BCMPW'(1)) >= BCMPW'(cfg.bpp);
	assign end_row = end_px && ((CMPW'(col_q) + CMPW'(1)) >= CMPW'(cfg.rect_w));
	assign last    = end_row && ((CMPW'(row_q) + CMPW'(1)) >= CMPW'(cfg.rect_h));

	assign row_sum  = RSW'(cfg.dst_y) + RSW'(row_q);
	assign pix_idx  = ADDR_W'(row_sum) * ADDR_W'(cfg.dst_width)
	                + ADDR_W'(cfg.dst_x) + ADDR_W'(col_q);
	assign byte_idx = BPP_W'(byte_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			byte_q <= '0;
		end else if (advance) begin
			if (!end_px) begin
				byte_q <= byte_q + BW'(1);
			end else begin
				byte_q <= '0;
				if (!end_row) begin
					col_q <= col_q + CW'(1);
				end else begin
					col_q <= '0;
					if (!last)
						row_q <= row_q + CW'(1);
					else
						row_q <= '0;
				end
			end
		end
	end

	// rectangle end rewinds every counter
	a_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> row_q == '0 && col_q == '0 && byte_q == '0)
		else $error("counters not rewound after last byte");

endmodule

FILE: rtl/core/rba_wr_stage.sv
// rba_wr_stage: second stage logic, byte address from pixel index and the
// blended or copied output byte. Depends on rba_pkg.
module rba_wr_stage import rba_pkg::*; (
	input  s1_t               s1,
	output logic [ADDR_W-1:0] addr,
	output logic [BYTE_W-1:0] data
);

	logic [ADDR_W-1:0]     scaled;
	logic [2*BYTE_W-1:0]   src_term;
	logic [2*BYTE_W-1:0]   dst_term;
	logic [2*BYTE_W-1:0]   mix;
	logic [ALPHA_W-1:0]    inv_alpha;

	assign scaled = ADDR_W'(s1.pix_idx * ADDR_W'(s1.bpp));
	assign addr   = scaled + ADDR_W'(s1.byte_idx);

	assign inv_alpha = ~s1.alpha;
	assign src_term  = (2*BYTE_W)'(s1.src) * (2*BYTE_W)'(s1.alpha);
	assign dst_term  = (2*BYTE_W)'(s1.dst) * (2*BYTE_W)'(inv_alpha);
	assign mix       = src_term + dst_term;
	assign data      = s1.blend_en ? mix[2*BYTE_W-1:BYTE_W] : s1.src;

endmodule
